### hw/rtl/pat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pat_pkg
// types, codes and sizes shared by the prepaid account table
// ----------------------------------------------------------------------------
package pat_pkg;

    // table size and slot number width
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_CREDIT = 3'd2;
    localparam logic [2:0] CMD_CHECK  = 3'd3;
    localparam logic [2:0] CMD_PAY    = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK           = 2'd0;
    localparam logic [1:0] STS_FULL         = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND    = 2'd2;
    localparam logic [1:0] STS_INSUFFICIENT = 2'd3;

    // input transfer
    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        card_key;
        logic signed [31:0] credit_amount;
        logic [14:0]        price;
    } t_in_item;

    // output transfer
    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         slot_index;
        logic signed [31:0] balance_after;
    } t_out_item;

    // balance unit operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_OUT
    } t_state;

endpackage : pat_pkg
`default_nettype wire

### hw/rtl/pat_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pat_alu
// saturating 33-bit balance adder, shared by credit, check and pay
// ----------------------------------------------------------------------------
module pat_alu
    import pat_pkg::*;
(
    input  wire t_alu_op            i_op,
    input  wire logic signed [31:0] i_balance,
    input  wire logic signed [31:0] i_credit,
    input  wire logic [14:0]        i_price,
    output logic signed [31:0]      o_result,
    output logic                    o_nonneg
);

    logic [32:0] opa;
    logic [32:0] opb;
    logic [32:0] sum;

    // operands: add credit, or subtract price by inverting and carrying in
    always_comb begin
        opa = {i_balance[31], i_balance};
        unique case (i_op)
            ALU_ADD: opb = {i_credit[31], i_credit};
            ALU_SUB: opb = ~{18'd0, i_price};
            default: opb = '0;
        endcase
        sum = opa + opb + {32'd0, (i_op == ALU_SUB)};
    end

    // saturate to the signed 32-bit range
    always_comb begin
        if (sum[32] != sum[31]) begin
            o_result = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            o_result = sum[31:0];
        end
        o_nonneg = ~sum[32];
    end

endmodule : pat_alu
`default_nettype wire

### hw/rtl/prepaid_account_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prepaid_account_table
// table of card accounts with add, remove, credit, check and pay commands
// ----------------------------------------------------------------------------
// One command comes in on the input channel (i_in_valid / o_in_stall,
// payload i_in_data) and gives exactly one result on the output channel
// (o_out_valid / i_out_stall, payload o_out_data). A transfer happens at a
// clock edge where valid is high and stall is low.
// The block handles one command at a time. A scan walks the slots one per
// cycle through the key and balance memories, whose read data is
// registered, so a command passes the accept, scan, execute and output
// steps in order; a match ends the scan early, and a scan that finds no
// match goes from scan straight to output. Unused command codes skip the
// scan and go from accept straight to output.
// o_in_stall is high from the accept until the result has been taken.
// A stalled result holds in the output register until i_out_stall drops.
// Synchronous reset clears all valid marks and the sequencer; the key and
// balance memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module prepaid_account_table
    import pat_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // state and storage
    t_state                   r_state;
    t_state                   n_state;
    logic [SLOT_COUNT-1:0]    r_slot_valid;
    logic [31:0]              key_mem [SLOT_COUNT];
    logic signed [31:0]       bal_mem [SLOT_COUNT];

    t_in_item                 r_cmd;
    logic [SLOT_W-1:0]        r_idx;
    logic [SLOT_W-1:0]        r_rd_idx;
    logic                     r_rd_live;
    logic [31:0]              r_rd_key;
    logic signed [31:0]       r_rd_bal;
    t_out_item                r_out;

    // control decode
    logic                     in_xfer;
    logic                     out_xfer;
    logic                     cmd_known;
    logic                     is_add;
    logic                     hit;
    logic                     scan_end;
    logic                     issue;

    // balance unit
    t_alu_op                  alu_op;
    logic signed [31:0]       alu_result;
    logic                     alu_nonneg;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_xfer  = o_out_valid && !i_out_stall;
    assign cmd_known = (i_in_data.command == CMD_ADD)
                    || (i_in_data.command == CMD_REMOVE)
                    || (i_in_data.command == CMD_CREDIT)
                    || (i_in_data.command == CMD_CHECK)
                    || (i_in_data.command == CMD_PAY);
    assign is_add    = (r_cmd.command == CMD_ADD);

    // slot compare on the registered read data
    always_comb begin
        if (is_add) begin
            hit = r_rd_live && !r_slot_valid[r_rd_idx];
        end else begin
            hit = r_rd_live && r_slot_valid[r_rd_idx] && (r_rd_key == r_cmd.card_key);
        end
        scan_end = r_rd_live && (r_rd_idx == LAST_SLOT) && !hit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = cmd_known ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_EXEC;
                end else if (scan_end) begin
                    n_state = ST_OUT;
                end
            end
            ST_EXEC: n_state = ST_OUT;
            ST_OUT: begin
                if (out_xfer) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and control strobes
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_out_data  = r_out;
        issue       = (r_state == ST_SCAN) && !hit && !scan_end;
        alu_op      = (r_cmd.command == CMD_CREDIT) ? ALU_ADD : ALU_SUB;
    end

    pat_alu u_alu (
        .i_op      (alu_op),
        .i_balance (r_rd_bal),
        .i_credit  (r_cmd.credit_amount),
        .i_price   (r_cmd.price),
        .o_result  (alu_result),
        .o_nonneg  (alu_nonneg)
    );

    // sequencer and valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= '0;
            r_rd_live    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_rd_live <= 1'b0;
            end else if (issue) begin
                r_rd_live <= 1'b1;
            end
            if (r_state == ST_EXEC) begin
                if (is_add) begin
                    r_slot_valid[r_rd_idx] <= 1'b1;
                end else if (r_cmd.command == CMD_REMOVE) begin
                    r_slot_valid[r_rd_idx] <= 1'b0;
                end
            end
        end
    end

    // command capture, scan address and memory read
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= i_in_data;
            r_idx <= '0;
        end else if (issue) begin
            r_rd_key <= key_mem[r_idx];
            r_rd_bal <= bal_mem[r_idx];
            r_rd_idx <= r_idx;
            r_idx    <= r_idx + 1'b1;
        end
    end

    // memory write on execute
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            if (is_add) begin
                key_mem[r_rd_idx] <= r_cmd.card_key;
                bal_mem[r_rd_idx] <= '0;
            end else if ((r_cmd.command == CMD_CREDIT) || (r_cmd.command == CMD_PAY)) begin
                bal_mem[r_rd_idx] <= alu_result;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (in_xfer && !cmd_known) begin
            r_out.status        <= STS_OK;
            r_out.slot_index    <= '0;
            r_out.balance_after <= '0;
        end else if ((r_state == ST_SCAN) && scan_end) begin
            r_out.status        <= is_add ? STS_FULL : STS_NOT_FOUND;
            r_out.slot_index    <= '0;
            r_out.balance_after <= '0;
        end else if (r_state == ST_EXEC) begin
            r_out.slot_index <= 4'(r_rd_idx);
            unique case (r_cmd.command)
                CMD_ADD: begin
                    r_out.status        <= STS_OK;
                    r_out.balance_after <= '0;
                end
                CMD_REMOVE: begin
                    r_out.status        <= STS_OK;
                    r_out.balance_after <= r_rd_bal;
                end
                CMD_CHECK: begin
                    r_out.status        <= alu_nonneg ? STS_OK : STS_INSUFFICIENT;
                    r_out.balance_after <= r_rd_bal;
                end
                default: begin
                    r_out.status        <= STS_OK;
                    r_out.balance_after <= alu_result;
                end
            endcase
        end
    end

endmodule : prepaid_account_table
`default_nettype wire

### dv/prepaid_account_table_tb.sv
// ----------------------------------------------------------------------------
// prepaid_account_table_tb
// self-checking bench for the prepaid account table
// ----------------------------------------------------------------------------
// Card commands are queued up front: a short directed list (empty table,
// duplicate keys, full table, balance saturation at both ends, insufficient
// balance, a spare code), then random traffic over a small key pool in phases
// that alternately grow and shrink the table. A driver feeds the commands in
// bursts with random gaps. A shadow of the slot table predicts one receipt
// per accepted command, and a monitor checks each receipt field by field
// while the result side stalls on patterns of its own.
// ----------------------------------------------------------------------------
module prepaid_account_table_tb
    import pat_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CMD_COUNT      = 1200;
    localparam int         PHASE_LEN      = 150;
    localparam int         POOL_SIZE      = 24;
    localparam int         CYCLE_LIMIT    = 500000;
    localparam int         SETTLE_CYCLES  = 40;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic [31:0] BAL_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] BAL_MIN       = 32'h8000_0000;
    localparam logic [14:0] PRICE_MAX     = 15'h7FFF;

    // one queued card command, optionally held until all receipts are in
    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_tap;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    t_tap      tap_q[$];
    t_out_item receipt_q[$];
    t_tap      next_tap;
    t_out_item got_receipt;
    t_out_item want_receipt;

    // shadow of the slot table
    bit          acct_valid[SLOT_COUNT];
    logic [31:0] acct_key[SLOT_COUNT];
    logic signed [31:0] acct_balance[SLOT_COUNT];

    logic [31:0] key_pool[POOL_SIZE];

    bit in_fired   = 1'b0;
    int gap_left   = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    prepaid_account_table uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // saturate a wide sum to the signed 32-bit range
    function automatic logic signed [31:0] clamp_balance(longint sum);
        if (sum > longint'($signed(BAL_MAX))) begin
            return $signed(BAL_MAX);
        end
        if (sum < longint'($signed(BAL_MIN))) begin
            return $signed(BAL_MIN);
        end
        return 32'(sum);
    endfunction

    // apply one command to the shadow table and return its receipt
    function automatic t_out_item apply_account_command(t_in_item cmd_in);
        t_out_item receipt;
        int        hit;
        longint    price_wide;
        receipt    = '0;
        hit        = -1;
        price_wide = longint'(cmd_in.price);
        receipt.status = STS_OK;
        if (cmd_in.command == CMD_ADD) begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                if (!acct_valid[i]) hit = i;
            end
            if (hit < 0) begin
                receipt.status = STS_FULL;
            end else begin
                acct_valid[hit]   = 1'b1;
                acct_key[hit]     = cmd_in.card_key;
                acct_balance[hit] = '0;
                receipt.slot_index = 4'(hit);
            end
            return receipt;
        end
        if (cmd_in.command > CMD_PAY) begin
            return receipt;
        end
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (acct_valid[i] && acct_key[i] == cmd_in.card_key) hit = i;
        end
        if (hit < 0) begin
            receipt.status = STS_NOT_FOUND;
            return receipt;
        end
        case (cmd_in.command)
            CMD_REMOVE: begin
                acct_valid[hit] = 1'b0;
            end
            CMD_CREDIT: begin
                acct_balance[hit] = clamp_balance(longint'(acct_balance[hit])
                                    + longint'($signed(cmd_in.credit_amount)));
            end
            CMD_CHECK: begin
                if (longint'(acct_balance[hit]) < price_wide) begin
                    receipt.status = STS_INSUFFICIENT;
                end
            end
            default: begin
                acct_balance[hit] = clamp_balance(longint'(acct_balance[hit])
                                    - price_wide);
            end
        endcase
        receipt.slot_index    = 4'(hit);
        receipt.balance_after = acct_balance[hit];
        return receipt;
    endfunction

    task automatic push_tap(logic [2:0] cmd, logic [31:0] key, logic [31:0] credit,
                            logic [14:0] price, bit drain);
        t_tap tap;
        tap.item.command       = cmd;
        tap.item.card_key      = key;
        tap.item.credit_amount = credit;
        tap.item.price         = price;
        tap.drain_first        = drain;
        tap_q.push_back(tap);
    endtask

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: receipt %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // input driver: bursts and gaps, payload held while stalled
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fired) begin
            in_valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            in_valid <= 1'b0;
        end else if (tap_q.size() != 0 &&
                     !(tap_q[0].drain_first && receipt_q.size() != 0)) begin
            next_tap = tap_q.pop_front();
            in_data  <= next_tap.item;
            in_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 8);
                gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result stall pattern: free-running, random, or mostly stalled
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(2);
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(2) == 0);
                default: out_stall <= ($urandom_range(7) != 0);
            endcase
        end
    end

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge clk) begin
        if (rst_n) begin
            in_fired <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                receipt_q.push_back(apply_account_command(in_data));
            end
            if (out_valid && !out_stall) begin
                got_receipt = out_data;
                if (receipt_q.size() == 0) begin
                    $display("%0t ns: receipt with none expected, actual %p",
                             $time, got_receipt);
                    mismatch_count++;
                end else begin
                    want_receipt = receipt_q.pop_front();
                    report_field("status", 32'(want_receipt.status),
                                 32'(got_receipt.status));
                    report_field("slot_index", 32'(want_receipt.slot_index),
                                 32'(got_receipt.slot_index));
                    report_field("balance_after", want_receipt.balance_after,
                                 got_receipt.balance_after);
                end
            end
        end else begin
            in_fired <= 1'b0;
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [31:0] credit;
        logic [14:0] price;
        int          roll;
        int          add_pct;
        int          remove_pct;
        bit          grow_phase;

        for (int i = 0; i < SLOT_COUNT; i++) begin
            acct_valid[i]   = 1'b0;
            acct_key[i]     = '0;
            acct_balance[i] = '0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end

        // empty table misses, and a spare code
        push_tap(CMD_REMOVE, key_pool[2], $urandom, 15'($urandom), 1'b0);
        push_tap(CMD_SPARE_LAST, $urandom, $urandom, 15'($urandom), 1'b0);
        // fill every slot, first key twice, then one more add
        push_tap(CMD_ADD, key_pool[2], $urandom, 15'($urandom), 1'b0);
        push_tap(CMD_ADD, key_pool[2], $urandom, 15'($urandom), 1'b0);
        push_tap(CMD_ADD, key_pool[0], $urandom, 15'($urandom), 1'b0);
        push_tap(CMD_ADD, key_pool[1], $urandom, 15'($urandom), 1'b0);
        for (int i = 0; i < SLOT_COUNT - 4; i++) begin
            push_tap(CMD_ADD, key_pool[3 + i], $urandom, 15'($urandom), 1'b0);
        end
        push_tap(CMD_ADD, key_pool[POOL_SIZE - 1], $urandom, 15'($urandom), 1'b0);
        // saturation at both ends and the balance check
        push_tap(CMD_CREDIT, key_pool[2], BAL_MAX, 15'($urandom), 1'b0);
        push_tap(CMD_CREDIT, key_pool[2], BAL_MAX, 15'($urandom), 1'b0);
        push_tap(CMD_CREDIT, key_pool[0], BAL_MIN, 15'($urandom), 1'b0);
        push_tap(CMD_PAY, key_pool[0], $urandom, PRICE_MAX, 1'b0);
        push_tap(CMD_CHECK, key_pool[1], $urandom, 15'd1, 1'b0);
        push_tap(CMD_CHECK, key_pool[2], $urandom, PRICE_MAX, 1'b0);
        // remove the first copy, the duplicate answers next
        push_tap(CMD_REMOVE, key_pool[2], $urandom, 15'($urandom), 1'b0);
        push_tap(CMD_CREDIT, key_pool[2], -32'sd5, 15'($urandom), 1'b0);
        push_tap(CMD_REMOVE, key_pool[POOL_SIZE - 1], $urandom, 15'($urandom), 1'b0);

        // random traffic, phases alternately grow and shrink the table
        for (int n = 0; n < CMD_COUNT; n++) begin
            grow_phase = ((n / PHASE_LEN) % 2) == 1;
            add_pct    = grow_phase ? 35 : 10;
            remove_pct = grow_phase ? 10 : 30;
            roll       = $urandom_range(99);
            if (roll < add_pct) begin
                cmd = CMD_ADD;
            end else if (roll < add_pct + remove_pct) begin
                cmd = CMD_REMOVE;
            end else if (roll < 65) begin
                cmd = CMD_CREDIT;
            end else if (roll < 80) begin
                cmd = CMD_CHECK;
            end else if (roll < 95) begin
                cmd = CMD_PAY;
            end else begin
                cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end
            key = ($urandom_range(9) == 0) ? $urandom
                                           : key_pool[$urandom_range(POOL_SIZE - 1)];
            roll = $urandom_range(9);
            if (roll < 5) begin
                credit = 32'(int'($urandom_range(2000)) - 1000);
            end else if (roll < 8) begin
                credit = $urandom;
            end else if (roll == 8) begin
                credit = BAL_MAX;
            end else begin
                credit = BAL_MIN;
            end
            price = ($urandom_range(1) == 0) ? 15'($urandom_range(200))
                                              : 15'($urandom_range(PRICE_MAX));
            push_tap(cmd, key, credit, price,
                     (n % PHASE_LEN == 0) || ($urandom_range(199) == 0));
        end

        // synchronous reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (tap_q.size() != 0 || in_valid || receipt_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && receipt_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule : prepaid_account_table_tb
